// ----- src/trlr_pkg.sv -----
// shared types and constants of the thick line and rectangle rasterizer
`default_nettype none

package trlr_pkg;

  localparam int DIM_BITS     = 13;
  localparam int OUT_BITS     = 12;
  localparam int PEN_BITS     = 8;
  localparam int HALF_BITS    = 7;
  localparam int COLOR_BITS   = 32;
  localparam int PIX_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIM_BITS-1:0] MAX_DIM    = 13'd4096;
  localparam logic [DIM_BITS-1:0] RST_WIDTH  = 13'd128;
  localparam logic [DIM_BITS-1:0] RST_HEIGHT = 13'd64;
  localparam logic                RST_MODE   = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_RECT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic step_x_neg;
    logic step_y_neg;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic                visible;
    logic                last;
    logic [PIX_BITS-1:0] color_lo;
    logic                color_nz;
  } paint_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                color_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/thick_line_rect_rasterizer.sv -----
// top level: config registers, front stage, queue, back stage and clip stage
// a result is registered in turn in the front register, the queue, the back output register
//   and the clip output register; the queue holds 2 entries by default
// throughput: one word per cycle unless out_ready stalls; each back-stage line step is
//   two compares and up to two error adds on the registered error state
// reset: synchronous rst empties all stages, ends any line, width 128, height 64, RGB565
`default_nettype none

module thick_line_rect_rasterizer #(
  parameter int COORD_BITS = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic signed [COORD_BITS-1:0]         ax,
  input  logic signed [COORD_BITS-1:0]         ay,
  input  logic signed [COORD_BITS-1:0]         bx,
  input  logic signed [COORD_BITS-1:0]         by,
  input  logic [trlr_pkg::PEN_BITS-1:0]        pen_width,
  input  logic [trlr_pkg::COLOR_BITS-1:0]      color_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 rect_valid,
  output logic [trlr_pkg::OUT_BITS-1:0]        left,
  output logic [trlr_pkg::OUT_BITS-1:0]        top,
  output logic [trlr_pkg::OUT_BITS-1:0]        right,
  output logic [trlr_pkg::OUT_BITS-1:0]        bottom,
  output logic [trlr_pkg::PIX_BITS-1:0]        pixel_value,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trlr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [trlr_pkg::DIM_BITS-1:0]        cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int CMDW = $bits(trlr_pkg::cmd_t);
  localparam int QW   = CMDW + 4 * C + 2 * (C + 1) + (C + 3)
                        + trlr_pkg::HALF_BITS + trlr_pkg::COLOR_BITS;

  trlr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width      <= trlr_pkg::RST_WIDTH;
      cfg.height     <= trlr_pkg::RST_HEIGHT;
      cfg.color_mode <= trlr_pkg::RST_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trlr_pkg::CFG_WIDTH:  cfg.width      <= cfg_data;
        trlr_pkg::CFG_HEIGHT: cfg.height     <= cfg_data;
        trlr_pkg::CFG_MODE:   cfg.color_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // front to queue
  logic                      f_valid, f_ready;
  trlr_pkg::cmd_t            f_cmd;
  logic signed [C-1:0]       f_p0x, f_p0y, f_p1x, f_p1y;
  logic signed [C:0]         f_dx, f_dyn;
  logic signed [C+2:0]       f_err;
  logic [trlr_pkg::HALF_BITS-1:0]  f_half;
  logic [trlr_pkg::COLOR_BITS-1:0] f_color;
  logic [QW-1:0]             f_word;

  // queue to back
  logic                      q_valid, q_ready;
  logic [QW-1:0]             q_word;
  trlr_pkg::cmd_t            q_cmd;
  logic signed [C-1:0]       q_p0x, q_p0y, q_p1x, q_p1y;
  logic signed [C:0]         q_dx, q_dyn;
  logic signed [C+2:0]       q_err;
  logic [trlr_pkg::HALF_BITS-1:0]  q_half;
  logic [trlr_pkg::COLOR_BITS-1:0] q_color;

  // back to clip
  logic                      b_valid, b_ready;
  trlr_pkg::paint_t          b_paint;
  logic signed [C:0]         b_x1, b_y1, b_x2, b_y2;

  trlr_front #(.COORD_BITS(C)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .ax        (ax),
    .ay        (ay),
    .bx        (bx),
    .by        (by),
    .pen_width (pen_width),
    .color_in  (color_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .cmd       (f_cmd),
    .p0x       (f_p0x),
    .p0y       (f_p0y),
    .p1x       (f_p1x),
    .p1y       (f_p1y),
    .dx        (f_dx),
    .dyn       (f_dyn),
    .err       (f_err),
    .half      (f_half),
    .color     (f_color)
  );

  assign f_word = {f_cmd, f_p0x, f_p0y, f_p1x, f_p1y, f_dx, f_dyn, f_err, f_half, f_color};

  trlr_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_word)
  );

  assign {q_cmd, q_p0x, q_p0y, q_p1x, q_p1y, q_dx, q_dyn, q_err, q_half, q_color} = q_word;

  trlr_back #(.COORD_BITS(C)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .cmd       (q_cmd),
    .p0x       (q_p0x),
    .p0y       (q_p0y),
    .p1x       (q_p1x),
    .p1y       (q_p1y),
    .dx        (q_dx),
    .dyn       (q_dyn),
    .err       (q_err),
    .half      (q_half),
    .color     (q_color),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .paint     (b_paint),
    .x1        (b_x1),
    .y1        (b_y1),
    .x2        (b_x2),
    .y2        (b_y2)
  );

  trlr_clip #(.COORD_BITS(C)) u_clip (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (b_valid),
    .in_ready    (b_ready),
    .paint       (b_paint),
    .x1          (b_x1),
    .y1          (b_y1),
    .x2          (b_x2),
    .y2          (b_y2),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rect_valid  (rect_valid),
    .left        (left),
    .top         (top),
    .right       (right),
    .bottom      (bottom),
    .pixel_value (pixel_value),
    .last        (last)
  );

endmodule

`default_nettype wire

// ----- src/trlr_front.sv -----
// front stage: accepts words, decodes the op and sets up line deltas
`default_nettype none

module trlr_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic signed [COORD_BITS-1:0]         ax,
  input  logic signed [COORD_BITS-1:0]         ay,
  input  logic signed [COORD_BITS-1:0]         bx,
  input  logic signed [COORD_BITS-1:0]         by,
  input  logic [trlr_pkg::PEN_BITS-1:0]        pen_width,
  input  logic [trlr_pkg::COLOR_BITS-1:0]      color_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output trlr_pkg::cmd_t                       cmd,
  output logic signed [COORD_BITS-1:0]         p0x,
  output logic signed [COORD_BITS-1:0]         p0y,
  output logic signed [COORD_BITS-1:0]         p1x,
  output logic signed [COORD_BITS-1:0]         p1y,
  output logic signed [COORD_BITS:0]           dx,
  output logic signed [COORD_BITS:0]           dyn,
  output logic signed [COORD_BITS+2:0]         err,
  output logic [trlr_pkg::HALF_BITS-1:0]       half,
  output logic [trlr_pkg::COLOR_BITS-1:0]      color
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 3;

  logic signed [DW-1:0] diff_x, diff_y, abs_x, abs_y;
  logic                 x_lt, y_lt, fire;
  trlr_pkg::cmd_t       cmd_next;
  logic signed [COORD_BITS-1:0] p0x_next, p0y_next, p1x_next, p1y_next;
  logic signed [EW-1:0] err_next;

  assign diff_x = DW'(bx) - DW'(ax);
  assign diff_y = DW'(by) - DW'(ay);
  assign abs_x  = diff_x[DW-1] ? -diff_x : diff_x;
  assign abs_y  = diff_y[DW-1] ? -diff_y : diff_y;
  assign x_lt   = ax < bx;
  assign y_lt   = ay < by;
  assign err_next = EW'(abs_x) - EW'(abs_y);

  always_comb begin
    cmd_next.op         = trlr_pkg::op_t'(op);
    cmd_next.step_x_neg = !x_lt;
    cmd_next.step_y_neg = !y_lt;
    cmd_next.done       = (ax == bx) && (ay == by);
    p0x_next = ax;
    p0y_next = ay;
    p1x_next = bx;
    p1y_next = by;
    // rectangles travel with sorted corners
    if (cmd_next.op == trlr_pkg::OP_RECT) begin
      p0x_next = x_lt ? ax : bx;
      p1x_next = x_lt ? bx : ax;
      p0y_next = y_lt ? ay : by;
      p1y_next = y_lt ? by : ay;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd   <= cmd_next;
      p0x   <= p0x_next;
      p0y   <= p0y_next;
      p1x   <= p1x_next;
      p1y   <= p1y_next;
      dx    <= abs_x;
      dyn   <= -abs_y;
      err   <= err_next;
      half  <= pen_width[trlr_pkg::PEN_BITS-1:1];
      color <= color_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/trlr_fifo.sv -----
// short queue between the front and back stages
`default_nettype none

module trlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = count != FULL_CNT;
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- src/trlr_back.sv -----
// back stage: holds the line state, steps it and forms the rectangle corners
`default_nettype none

module trlr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  trlr_pkg::cmd_t                       cmd,
  input  logic signed [COORD_BITS-1:0]         p0x,
  input  logic signed [COORD_BITS-1:0]         p0y,
  input  logic signed [COORD_BITS-1:0]         p1x,
  input  logic signed [COORD_BITS-1:0]         p1y,
  input  logic signed [COORD_BITS:0]           dx,
  input  logic signed [COORD_BITS:0]           dyn,
  input  logic signed [COORD_BITS+2:0]         err,
  input  logic [trlr_pkg::HALF_BITS-1:0]       half,
  input  logic [trlr_pkg::COLOR_BITS-1:0]      color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output trlr_pkg::paint_t                     paint,
  output logic signed [COORD_BITS:0]           x1,
  output logic signed [COORD_BITS:0]           y1,
  output logic signed [COORD_BITS:0]           x2,
  output logic signed [COORD_BITS:0]           y2
);

  localparam int DW  = COORD_BITS + 1;
  localparam int EW  = COORD_BITS + 3;
  localparam int E2W = COORD_BITS + 4;
  localparam int PW  = COORD_BITS + 1;
  localparam int HW  = trlr_pkg::HALF_BITS;

  logic signed [COORD_BITS-1:0] pos_x, pos_y, end_x, end_y;
  logic signed [DW-1:0]         delta_x, delta_y_neg;
  logic                         step_x_neg, step_y_neg, line_active;
  logic signed [EW-1:0]         error_term, error_next;
  logic [HW-1:0]                half_pen;
  logic [trlr_pkg::COLOR_BITS-1:0] line_color;

  logic signed [E2W-1:0]        e2;
  logic                         move_x, move_y, step_done, fire;
  logic signed [COORD_BITS-1:0] inc_x, inc_y, pos_x_next, pos_y_next;
  logic signed [COORD_BITS-1:0] ctr_x, ctr_y;
  logic [HW-1:0]                ctr_half;
  logic signed [PW-1:0]         half_s;
  logic [trlr_pkg::COLOR_BITS-1:0] sel_color;
  trlr_pkg::paint_t             paint_next;
  logic signed [PW-1:0]         x1_next, y1_next, x2_next, y2_next;

  localparam logic signed [COORD_BITS-1:0] PLUS_ONE  = COORD_BITS'(1);
  localparam logic signed [COORD_BITS-1:0] MINUS_ONE = '1;

  assign e2     = E2W'(error_term) <<< 1;
  assign move_x = e2 >= E2W'(delta_y_neg);
  assign move_y = e2 <= E2W'(delta_x);
  assign inc_x  = step_x_neg ? MINUS_ONE : PLUS_ONE;
  assign inc_y  = step_y_neg ? MINUS_ONE : PLUS_ONE;

  always_comb begin
    error_next = error_term;
    if (move_x) begin
      error_next = error_next + EW'(delta_y_neg);
    end
    if (move_y) begin
      error_next = error_next + EW'(delta_x);
    end
  end

  assign pos_x_next = move_x ? pos_x + inc_x : pos_x;
  assign pos_y_next = move_y ? pos_y + inc_y : pos_y;
  assign step_done  = (pos_x_next == end_x) && (pos_y_next == end_y);

  always_comb begin
    ctr_x      = p0x;
    ctr_y      = p0y;
    ctr_half   = half;
    sel_color  = color;
    paint_next.visible = 1'b1;
    paint_next.last    = 1'b1;
    unique case (cmd.op)
      trlr_pkg::OP_START: begin
        paint_next.last = cmd.done;
      end
      trlr_pkg::OP_STEP: begin
        ctr_x     = pos_x_next;
        ctr_y     = pos_y_next;
        ctr_half  = half_pen;
        sel_color = line_color;
        paint_next.visible = line_active;
        paint_next.last    = !line_active || step_done;
      end
      trlr_pkg::OP_RECT: begin
        paint_next.last = 1'b1;
      end
      default: begin
        paint_next.visible = 1'b0;
      end
    endcase
    paint_next.color_lo = sel_color[trlr_pkg::PIX_BITS-1:0];
    paint_next.color_nz = sel_color != '0;
    half_s  = PW'($signed({1'b0, ctr_half}));
    x1_next = PW'(ctr_x) - half_s;
    y1_next = PW'(ctr_y) - half_s;
    x2_next = PW'(ctr_x) + half_s;
    y2_next = PW'(ctr_y) + half_s;
    if (cmd.op == trlr_pkg::OP_RECT) begin
      x1_next = PW'(p0x);
      y1_next = PW'(p0y);
      x2_next = PW'(p1x);
      y2_next = PW'(p1y);
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      line_active <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire && cmd.op == trlr_pkg::OP_START) begin
        line_active <= !cmd.done;
      end else if (fire && cmd.op == trlr_pkg::OP_STEP && line_active && step_done) begin
        line_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.op == trlr_pkg::OP_START) begin
      pos_x       <= p0x;
      pos_y       <= p0y;
      end_x       <= p1x;
      end_y       <= p1y;
      delta_x     <= dx;
      delta_y_neg <= dyn;
      step_x_neg  <= cmd.step_x_neg;
      step_y_neg  <= cmd.step_y_neg;
      error_term  <= err;
      half_pen    <= half;
      line_color  <= color;
    end else if (fire && cmd.op == trlr_pkg::OP_STEP && line_active) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      error_term <= error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      paint <= paint_next;
      x1    <= x1_next;
      y1    <= y1_next;
      x2    <= x2_next;
      y2    <= y2_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_line_end: assert property (@(posedge clk) disable iff (rst)
    $fell(line_active) && !$past(rst) |->
      $past(fire && (cmd.op == trlr_pkg::OP_STEP || cmd.op == trlr_pkg::OP_START)))
    else $error("line ended without a start or step word");
`endif

endmodule

`default_nettype wire

// ----- src/trlr_clip.sv -----
// clip stage: clips the rectangle to the screen and holds the result register
`default_nettype none

module trlr_clip #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  trlr_pkg::paint_t                   paint,
  input  logic signed [COORD_BITS:0]         x1,
  input  logic signed [COORD_BITS:0]         y1,
  input  logic signed [COORD_BITS:0]         x2,
  input  logic signed [COORD_BITS:0]         y2,
  input  trlr_pkg::cfg_t                     cfg,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               rect_valid,
  output logic [trlr_pkg::OUT_BITS-1:0]      left,
  output logic [trlr_pkg::OUT_BITS-1:0]      top,
  output logic [trlr_pkg::OUT_BITS-1:0]      right,
  output logic [trlr_pkg::OUT_BITS-1:0]      bottom,
  output logic [trlr_pkg::PIX_BITS-1:0]      pixel_value,
  output logic                               last
);

  localparam int PW = COORD_BITS + 1;
  localparam int CW = (PW > trlr_pkg::DIM_BITS + 1) ? PW : trlr_pkg::DIM_BITS + 1;
  localparam int OB = trlr_pkg::OUT_BITS;
  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic signed [CW-1:0] ONE  = CW'(1);

  logic [trlr_pkg::DIM_BITS-1:0] w, h;
  logic signed [CW-1:0] ws, hs, wm1, hm1, cx1, cy1, cx2, cy2;
  logic                 vis, fire;
  logic [OB-1:0]        left_next, top_next, right_next, bottom_next;
  logic [trlr_pkg::PIX_BITS-1:0] pixel_next;

  function automatic logic [OB-1:0] clamp_dim(input logic signed [CW-1:0] v,
                                              input logic signed [CW-1:0] hi);
    logic [OB-1:0] r;
    if (v < ZERO) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[OB-1:0];
    end else begin
      r = v[OB-1:0];
    end
    return r;
  endfunction

  assign w   = (cfg.width  > trlr_pkg::MAX_DIM) ? trlr_pkg::MAX_DIM : cfg.width;
  assign h   = (cfg.height > trlr_pkg::MAX_DIM) ? trlr_pkg::MAX_DIM : cfg.height;
  assign ws  = CW'($signed({1'b0, w}));
  assign hs  = CW'($signed({1'b0, h}));
  assign wm1 = ws - ONE;
  assign hm1 = hs - ONE;
  assign cx1 = CW'(x1);
  assign cy1 = CW'(y1);
  assign cx2 = CW'(x2);
  assign cy2 = CW'(y2);

  assign vis = paint.visible && (w != '0) && (h != '0) && !(cx2 < ZERO) && !(cy2 < ZERO)
               && !(cx1 >= ws) && !(cy1 >= hs);

  always_comb begin
    left_next   = '0;
    top_next    = '0;
    right_next  = '0;
    bottom_next = '0;
    pixel_next  = '0;
    if (vis) begin
      left_next   = clamp_dim(cx1, wm1);
      top_next    = clamp_dim(cy1, hm1);
      right_next  = clamp_dim(cx2, wm1);
      bottom_next = clamp_dim(cy2, hm1);
      pixel_next  = cfg.color_mode ? paint.color_lo
                                   : {{(trlr_pkg::PIX_BITS-1){1'b0}}, paint.color_nz};
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rect_valid  <= vis;
      left        <= left_next;
      top         <= top_next;
      right       <= right_next;
      bottom      <= bottom_next;
      pixel_value <= pixel_next;
      last        <= paint.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && rect_valid |-> (left <= right) && (top <= bottom))
    else $error("clipped rectangle corners out of order");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rect_valid |-> (pixel_value == '0) && (left == '0) && (right == '0))
    else $error("empty rectangle with nonzero fields");
`endif

endmodule

`default_nettype wire
